// ----- sv/distorted_pinhole_projection_assert.svh -----
// Assertion helpers used by the file that checks the projection pipeline.
`ifndef DISTORTED_PINHOLE_PROJECTION_ASSERT_SVH
`define DISTORTED_PINHOLE_PROJECTION_ASSERT_SVH

// Same-cycle implication, sampled on the block clock outside reset.
`define DPP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the block clock outside reset.
`define DPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/dpp_pkg.sv -----
package dpp_pkg;

	typedef logic signed [63:0] q32_t;
	typedef logic [3:0] cfg_idx_t;

	localparam cfg_idx_t REG_FOCAL_X   = 4'd0;
	localparam cfg_idx_t REG_FOCAL_Y   = 4'd1;
	localparam cfg_idx_t REG_PRINCIPAL = 4'd2;
	localparam cfg_idx_t REG_RADIAL_K1 = 4'd3;
	localparam cfg_idx_t REG_RADIAL_K2 = 4'd4;
	localparam cfg_idx_t REG_RADIAL_K3 = 4'd5;
	localparam cfg_idx_t REG_TANG_P1   = 4'd6;
	localparam cfg_idx_t REG_TANG_P2   = 4'd7;

	localparam q32_t Q32_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q32_t Q32_MIN = 64'sh8000_0000_0000_0000;
	localparam q32_t Q32_ONE = 64'sh0000_0001_0000_0000;

	localparam int DIV_STAGES = 32;

	typedef struct packed {
		logic [31:0] rem;
		logic [63:0] nq;
	} div_st_t;

	typedef struct packed {
		logic signed [31:0] pixel_u;
		logic signed [31:0] pixel_v;
		logic signed [31:0] jac_u_x;
		logic signed [31:0] jac_u_y;
		logic signed [31:0] jac_u_z;
		logic signed [31:0] jac_v_x;
		logic signed [31:0] jac_v_y;
		logic signed [31:0] jac_v_z;
		logic               depth_invalid;
	} res_t;

	function automatic q32_t sat_add(input q32_t a, input q32_t b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? Q32_MIN : Q32_MAX;
		end
		return q32_t'(s[63:0]);
	endfunction

	function automatic q32_t sat_scale(input q32_t a, input logic [2:0] k);
		logic [67:0] p;
		p = {{4{a[63]}}, a} * {65'd0, k};
		if (p[67:63] == 5'b00000 || p[67:63] == 5'b11111) begin
			return q32_t'(p[63:0]);
		end
		return p[67] ? Q32_MIN : Q32_MAX;
	endfunction

	function automatic q32_t sat_neg(input q32_t a);
		return (a == Q32_MIN) ? Q32_MAX : -a;
	endfunction

	function automatic q32_t from_mag(input logic neg, input logic [63:0] m);
		if (m[63]) begin
			return neg ? Q32_MIN : Q32_MAX;
		end
		return neg ? q32_t'(64'd0 - m) : q32_t'(m);
	endfunction

	function automatic logic [31:0] out32(input q32_t a);
		logic [63:0] m;
		logic [64:0] r;
		logic [48:0] q;
		logic [31:0] res;
		m = a[63] ? 64'(-a) : 64'(a);
		r = {1'b0, m} + 65'd32768;
		q = r[64:16];
		if (!a[63]) begin
			res = (q > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end else begin
			res = (q > 49'h0_8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
		end
		return res;
	endfunction

	function automatic q32_t coef(input logic [31:0] r);
		return q32_t'({{28{r[31]}}, r, 4'd0});
	endfunction

	function automatic div_st_t div_step(input div_st_t st, input logic [31:0] d);
		div_st_t o;
		logic [32:0] t;
		logic ge;
		t = {st.rem, st.nq[63]};
		ge = (t >= {1'b0, d});
		o.rem = ge ? 32'(t - {1'b0, d}) : t[31:0];
		o.nq = {st.nq[62:0], ge};
		return o;
	endfunction

endpackage

// ----- sv/dpp_div.sv -----
module dpp_div import dpp_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [63:0] quot
);

	div_st_t     st_s  [DIV_STAGES];
	logic [31:0] den_s [DIV_STAGES];

	genvar gi;
	generate
		for (gi = 0; gi < DIV_STAGES; gi++) begin : g_stage
			div_st_t     prev;
			div_st_t     mid;
			logic [31:0] dprev;
			if (gi == 0) begin : g_first
				assign prev  = {32'd0, num};
				assign dprev = den;
			end else begin : g_rest
				assign prev  = st_s[gi-1];
				assign dprev = den_s[gi-1];
			end
			assign mid = div_step(prev, dprev);
			always_ff @(posedge clk) begin
				if (en) begin
					st_s[gi]  <= div_step(mid, dprev);
					den_s[gi] <= dprev;
				end
			end
		end
	endgenerate

	assign quot = st_s[DIV_STAGES-1].nq;

endmodule

// ----- sv/dpp_mul.sv -----
module dpp_mul import dpp_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q32_t a,
	input  q32_t b,
	output q32_t p
);

	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  ma_s1, mb_s1;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [95:0]  hi_s3;
	q32_t         p_s4;
	logic [127:0] sum;

	// Rounding constant is half of the 32 fraction bits that are dropped.
	always_comb begin
		sum = {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
			+ {p11_s2, 64'd0} + 128'h8000_0000;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[63] ^ b[63];
			ma_s1  <= a[63] ? 64'(-a) : 64'(a);
			mb_s1  <= b[63] ? 64'(-b) : 64'(b);
			neg_s2 <= neg_s1;
			p00_s2 <= 64'(ma_s1[31:0]) * 64'(mb_s1[31:0]);
			p01_s2 <= 64'(ma_s1[31:0]) * 64'(mb_s1[63:32]);
			p10_s2 <= 64'(ma_s1[63:32]) * 64'(mb_s1[31:0]);
			p11_s2 <= 64'(ma_s1[63:32]) * 64'(mb_s1[63:32]);
			neg_s3 <= neg_s2;
			hi_s3  <= sum[127:32];
			if (|hi_s3[95:63]) begin
				p_s4 <= neg_s3 ? Q32_MIN : Q32_MAX;
			end else begin
				p_s4 <= neg_s3 ? q32_t'(64'd0 - hi_s3[63:0]) : q32_t'(hi_s3[63:0]);
			end
		end
	end

	assign p = p_s4;

endmodule

// ----- sv/distorted_pinhole_projection.sv -----
// Projects a camera-frame point through a pinhole camera with radial (k1, k2, k3) and
// tangential (p1, p2) lens distortion, and returns the distorted pixel and its 2x3 Jacobian
// with respect to the point. One word is accepted every clock cycle while in_stall is low; each
// result passes through the 32-stage radix-4 divider for x/z, y/z and 1/z and then a chain of
// pipelined multipliers and saturating adders. A two-entry output buffer lets the block keep
// accepting while a finished result waits; when both entries are full the whole pipeline holds.
// A point with zero or negative depth comes out with depth_invalid set and every other field
// zero. The user must write configuration registers only while the pipeline is empty;
// the block itself does not enforce this.
module distorted_pinhole_projection import dpp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pixel_u,
	output logic signed [31:0] pixel_v,
	output logic signed [31:0] jac_u_x,
	output logic signed [31:0] jac_u_y,
	output logic signed [31:0] jac_u_z,
	output logic signed [31:0] jac_v_x,
	output logic signed [31:0] jac_v_y,
	output logic signed [31:0] jac_v_z,
	output logic               depth_invalid
);

	logic [31:0] focal_x_q, focal_y_q, k1_q, k2_q, k3_q, p1_q, p2_q;
	logic [63:0] pp_q;
	q32_t        fx, fy, cx, cy, k1, k2, k3, p1, p2;

	logic        adv;
	logic [69:1] vld_s;
	logic [69:1] bad_s;

	logic signed [31:0] x_s1, y_s1, z_s1;
	logic [31:0] dz, mx, my;
	logic [63:0] nx_s2, ny_s2, nw_s2;
	logic [31:0] den_s2;
	logic [34:2] sgx_s, sgy_s;
	logic [63:0] qx, qy, qw;

	q32_t u_s [35:56];
	q32_t v_s [35:56];
	q32_t w_s [35:61];
	q32_t u2_s [40:49];
	q32_t v2_s [40:49];
	q32_t uv_s [40:49];
	q32_t p1v_s [40:55];
	q32_t p2u_s [40:55];
	q32_t p1u_s [40:55];
	q32_t p2v_s [40:55];
	q32_t r2_s [40:44];
	q32_t ru_s41, rv_s41;
	q32_t p1uv_s [44:45];
	q32_t p2uv_s [44:45];
	q32_t e1_s [45:48];
	q32_t g1_s [45:48];
	q32_t tx_s [46:57];
	q32_t ty_s [46:57];
	q32_t e2_s [49:52];
	q32_t g_s49, dr_s53;
	q32_t a1_s54, d1_s54, b1_s54, a2_s55, d2_s55, b_s55, a_s56, d_s56, b_s56;
	q32_t xd_s58, yd_s58, sx_s61, sy_s61;
	q32_t pu_s [63:69];
	q32_t pv_s [63:69];
	q32_t jux_s [65:69];
	q32_t juy_s [65:69];
	q32_t jvx_s [65:69];
	q32_t jvy_s [65:69];

	q32_t m_u2, m_v2, m_uv, m_p1v, m_p2u, m_p1u, m_p2v, m_p1uv, m_p2uv;
	q32_t m_r4, m_k1r2, m_k2r2, m_p2ru, m_p1rv, m_r6, m_k2r4, m_k3r4, m_k3r6;
	q32_t m_u2g, m_v2g, m_uvg, m_dru, m_drv, m_fxxd, m_fyyd;
	q32_t m_au, m_bv, m_bu, m_dv, m_aw, m_bw, m_dw, m_sxw, m_syw;
	q32_t m_fxaw, m_fxbw, m_fybw, m_fydw, m_fxsxw, m_fysyw;

	res_t fin, out_q, skid_q;
	logic ov_q, sv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= 32'h0001_0000;
			focal_y_q <= 32'h0001_0000;
			pp_q      <= 64'd0;
			k1_q      <= 32'd0;
			k2_q      <= 32'd0;
			k3_q      <= 32'd0;
			p1_q      <= 32'd0;
			p2_q      <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:   focal_x_q <= cfg_data[31:0];
				REG_FOCAL_Y:   focal_y_q <= cfg_data[31:0];
				REG_PRINCIPAL: pp_q      <= cfg_data;
				REG_RADIAL_K1: k1_q      <= cfg_data[31:0];
				REG_RADIAL_K2: k2_q      <= cfg_data[31:0];
				REG_RADIAL_K3: k3_q      <= cfg_data[31:0];
				REG_TANG_P1:   p1_q      <= cfg_data[31:0];
				REG_TANG_P2:   p2_q      <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign fx = q32_t'({16'd0, focal_x_q, 16'd0});
	assign fy = q32_t'({16'd0, focal_y_q, 16'd0});
	assign cx = q32_t'({16'd0, pp_q[31:0], 16'd0});
	assign cy = q32_t'({16'd0, pp_q[63:32], 16'd0});
	assign k1 = coef(k1_q);
	assign k2 = coef(k2_q);
	assign k3 = coef(k3_q);
	assign p1 = coef(p1_q);
	assign p2 = coef(p2_q);

	assign adv      = !sv_q;
	assign in_stall = sv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[68:1], in_valid};
		end
	end

	// A bad depth still runs through the divider with a divisor of one.
	always_comb begin
		dz = bad_s[1] ? 32'd1 : 32'(z_s1);
		mx = x_s1[31] ? 32'(-x_s1) : 32'(x_s1);
		my = y_s1[31] ? 32'(-y_s1) : 32'(y_s1);
	end

	dpp_div u_div_x (.clk, .en(adv), .num(nx_s2), .den(den_s2), .quot(qx));
	dpp_div u_div_y (.clk, .en(adv), .num(ny_s2), .den(den_s2), .quot(qy));
	dpp_div u_div_w (.clk, .en(adv), .num(nw_s2), .den(den_s2), .quot(qw));

	dpp_mul u_mul_u2   (.clk, .en(adv), .a(u_s[35]), .b(u_s[35]), .p(m_u2));
	dpp_mul u_mul_v2   (.clk, .en(adv), .a(v_s[35]), .b(v_s[35]), .p(m_v2));
	dpp_mul u_mul_uv   (.clk, .en(adv), .a(u_s[35]), .b(v_s[35]), .p(m_uv));
	dpp_mul u_mul_p1v  (.clk, .en(adv), .a(p1), .b(v_s[35]), .p(m_p1v));
	dpp_mul u_mul_p2u  (.clk, .en(adv), .a(p2), .b(u_s[35]), .p(m_p2u));
	dpp_mul u_mul_p1u  (.clk, .en(adv), .a(p1), .b(u_s[35]), .p(m_p1u));
	dpp_mul u_mul_p2v  (.clk, .en(adv), .a(p2), .b(v_s[35]), .p(m_p2v));
	dpp_mul u_mul_p1uv (.clk, .en(adv), .a(p1), .b(m_uv), .p(m_p1uv));
	dpp_mul u_mul_p2uv (.clk, .en(adv), .a(p2), .b(m_uv), .p(m_p2uv));
	dpp_mul u_mul_r4   (.clk, .en(adv), .a(r2_s[40]), .b(r2_s[40]), .p(m_r4));
	dpp_mul u_mul_k1r2 (.clk, .en(adv), .a(k1), .b(r2_s[40]), .p(m_k1r2));
	dpp_mul u_mul_k2r2 (.clk, .en(adv), .a(k2), .b(r2_s[40]), .p(m_k2r2));
	dpp_mul u_mul_p2ru (.clk, .en(adv), .a(p2), .b(ru_s41), .p(m_p2ru));
	dpp_mul u_mul_p1rv (.clk, .en(adv), .a(p1), .b(rv_s41), .p(m_p1rv));
	dpp_mul u_mul_r6   (.clk, .en(adv), .a(m_r4), .b(r2_s[44]), .p(m_r6));
	dpp_mul u_mul_k2r4 (.clk, .en(adv), .a(k2), .b(m_r4), .p(m_k2r4));
	dpp_mul u_mul_k3r4 (.clk, .en(adv), .a(k3), .b(m_r4), .p(m_k3r4));
	dpp_mul u_mul_k3r6 (.clk, .en(adv), .a(k3), .b(m_r6), .p(m_k3r6));
	dpp_mul u_mul_u2g  (.clk, .en(adv), .a(u2_s[49]), .b(g_s49), .p(m_u2g));
	dpp_mul u_mul_v2g  (.clk, .en(adv), .a(v2_s[49]), .b(g_s49), .p(m_v2g));
	dpp_mul u_mul_uvg  (.clk, .en(adv), .a(uv_s[49]), .b(g_s49), .p(m_uvg));
	dpp_mul u_mul_dru  (.clk, .en(adv), .a(dr_s53), .b(u_s[53]), .p(m_dru));
	dpp_mul u_mul_drv  (.clk, .en(adv), .a(dr_s53), .b(v_s[53]), .p(m_drv));
	dpp_mul u_mul_au   (.clk, .en(adv), .a(a_s56), .b(u_s[56]), .p(m_au));
	dpp_mul u_mul_bv   (.clk, .en(adv), .a(b_s56), .b(v_s[56]), .p(m_bv));
	dpp_mul u_mul_bu   (.clk, .en(adv), .a(b_s56), .b(u_s[56]), .p(m_bu));
	dpp_mul u_mul_dv   (.clk, .en(adv), .a(d_s56), .b(v_s[56]), .p(m_dv));
	dpp_mul u_mul_aw   (.clk, .en(adv), .a(a_s56), .b(w_s[56]), .p(m_aw));
	dpp_mul u_mul_bw   (.clk, .en(adv), .a(b_s56), .b(w_s[56]), .p(m_bw));
	dpp_mul u_mul_dw   (.clk, .en(adv), .a(d_s56), .b(w_s[56]), .p(m_dw));
	dpp_mul u_mul_fxxd (.clk, .en(adv), .a(fx), .b(xd_s58), .p(m_fxxd));
	dpp_mul u_mul_fyyd (.clk, .en(adv), .a(fy), .b(yd_s58), .p(m_fyyd));
	dpp_mul u_mul_fxaw (.clk, .en(adv), .a(fx), .b(m_aw), .p(m_fxaw));
	dpp_mul u_mul_fxbw (.clk, .en(adv), .a(fx), .b(m_bw), .p(m_fxbw));
	dpp_mul u_mul_fybw (.clk, .en(adv), .a(fy), .b(m_bw), .p(m_fybw));
	dpp_mul u_mul_fydw (.clk, .en(adv), .a(fy), .b(m_dw), .p(m_fydw));
	dpp_mul u_mul_sxw  (.clk, .en(adv), .a(sx_s61), .b(w_s[61]), .p(m_sxw));
	dpp_mul u_mul_syw  (.clk, .en(adv), .a(sy_s61), .b(w_s[61]), .p(m_syw));
	dpp_mul u_mul_fxsx (.clk, .en(adv), .a(fx), .b(m_sxw), .p(m_fxsxw));
	dpp_mul u_mul_fysy (.clk, .en(adv), .a(fy), .b(m_syw), .p(m_fysyw));

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= point_x;
			y_s1  <= point_y;
			z_s1  <= point_z;
			bad_s <= {bad_s[68:1], point_z[31] | (point_z == 32'sd0)};

			nx_s2  <= {mx, 32'd0} + {33'd0, dz[31:1]};
			ny_s2  <= {my, 32'd0} + {33'd0, dz[31:1]};
			nw_s2  <= 64'h0001_0000_0000_0000 + {33'd0, dz[31:1]};
			den_s2 <= dz;
			sgx_s  <= {sgx_s[33:2], x_s1[31]};
			sgy_s  <= {sgy_s[33:2], y_s1[31]};

			u_s[35] <= from_mag(sgx_s[34], qx);
			v_s[35] <= from_mag(sgy_s[34], qy);
			w_s[35] <= from_mag(1'b0, qw);
			for (int i = 36; i <= 56; i++) begin
				u_s[i] <= u_s[i-1];
				v_s[i] <= v_s[i-1];
			end
			for (int i = 36; i <= 61; i++) begin
				w_s[i] <= w_s[i-1];
			end

			u2_s[40]  <= m_u2;
			v2_s[40]  <= m_v2;
			uv_s[40]  <= m_uv;
			for (int i = 41; i <= 49; i++) begin
				u2_s[i] <= u2_s[i-1];
				v2_s[i] <= v2_s[i-1];
				uv_s[i] <= uv_s[i-1];
			end
			p1v_s[40] <= m_p1v;
			p2u_s[40] <= m_p2u;
			p1u_s[40] <= m_p1u;
			p2v_s[40] <= m_p2v;
			for (int i = 41; i <= 55; i++) begin
				p1v_s[i] <= p1v_s[i-1];
				p2u_s[i] <= p2u_s[i-1];
				p1u_s[i] <= p1u_s[i-1];
				p2v_s[i] <= p2v_s[i-1];
			end
			r2_s[40] <= sat_add(m_u2, m_v2);
			for (int i = 41; i <= 44; i++) begin
				r2_s[i] <= r2_s[i-1];
			end

			ru_s41 <= sat_add(r2_s[40], sat_scale(u2_s[40], 3'd2));
			rv_s41 <= sat_add(r2_s[40], sat_scale(v2_s[40], 3'd2));

			p1uv_s[44] <= m_p1uv;
			p2uv_s[44] <= m_p2uv;
			p1uv_s[45] <= p1uv_s[44];
			p2uv_s[45] <= p2uv_s[44];

			e1_s[45] <= sat_add(Q32_ONE, m_k1r2);
			g1_s[45] <= sat_add(k1, sat_scale(m_k2r2, 3'd2));
			for (int i = 46; i <= 48; i++) begin
				e1_s[i] <= e1_s[i-1];
				g1_s[i] <= g1_s[i-1];
			end

			tx_s[46] <= sat_add(sat_scale(p1uv_s[45], 3'd2), m_p2ru);
			ty_s[46] <= sat_add(m_p1rv, sat_scale(p2uv_s[45], 3'd2));
			for (int i = 47; i <= 57; i++) begin
				tx_s[i] <= tx_s[i-1];
				ty_s[i] <= ty_s[i-1];
			end

			e2_s[49] <= sat_add(e1_s[48], m_k2r4);
			for (int i = 50; i <= 52; i++) begin
				e2_s[i] <= e2_s[i-1];
			end
			g_s49  <= sat_add(g1_s[48], sat_scale(m_k3r4, 3'd3));
			dr_s53 <= sat_add(e2_s[52], m_k3r6);

			a1_s54 <= sat_add(dr_s53, sat_scale(m_u2g, 3'd2));
			d1_s54 <= sat_add(dr_s53, sat_scale(m_v2g, 3'd2));
			b1_s54 <= sat_add(sat_scale(m_uvg, 3'd2), sat_scale(p1u_s[53], 3'd2));
			a2_s55 <= sat_add(a1_s54, sat_scale(p1v_s[54], 3'd2));
			d2_s55 <= sat_add(d1_s54, sat_scale(p1v_s[54], 3'd6));
			b_s55  <= sat_add(b1_s54, sat_scale(p2v_s[54], 3'd2));
			a_s56  <= sat_add(a2_s55, sat_scale(p2u_s[55], 3'd6));
			d_s56  <= sat_add(d2_s55, sat_scale(p2u_s[55], 3'd2));
			b_s56  <= b_s55;

			xd_s58 <= sat_add(m_dru, tx_s[57]);
			yd_s58 <= sat_add(m_drv, ty_s[57]);
			sx_s61 <= sat_add(m_au, m_bv);
			sy_s61 <= sat_add(m_bu, m_dv);

			pu_s[63] <= sat_add(cx, m_fxxd);
			pv_s[63] <= sat_add(cy, m_fyyd);
			for (int i = 64; i <= 69; i++) begin
				pu_s[i] <= pu_s[i-1];
				pv_s[i] <= pv_s[i-1];
			end
			jux_s[65] <= m_fxaw;
			juy_s[65] <= m_fxbw;
			jvx_s[65] <= m_fybw;
			jvy_s[65] <= m_fydw;
			for (int i = 66; i <= 69; i++) begin
				jux_s[i] <= jux_s[i-1];
				juy_s[i] <= juy_s[i-1];
				jvx_s[i] <= jvx_s[i-1];
				jvy_s[i] <= jvy_s[i-1];
			end
		end
	end

	always_comb begin
		fin.depth_invalid = bad_s[69];
		if (bad_s[69]) begin
			fin.pixel_u = '0;
			fin.pixel_v = '0;
			fin.jac_u_x = '0;
			fin.jac_u_y = '0;
			fin.jac_u_z = '0;
			fin.jac_v_x = '0;
			fin.jac_v_y = '0;
			fin.jac_v_z = '0;
		end else begin
			fin.pixel_u = out32(pu_s[69]);
			fin.pixel_v = out32(pv_s[69]);
			fin.jac_u_x = out32(jux_s[69]);
			fin.jac_u_y = out32(juy_s[69]);
			fin.jac_u_z = out32(sat_neg(m_fxsxw));
			fin.jac_v_x = out32(jvx_s[69]);
			fin.jac_v_y = out32(jvy_s[69]);
			fin.jac_v_z = out32(sat_neg(m_fysyw));
		end
	end

	// The skid entry takes the word leaving the pipeline while the output word is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (!out_stall) begin
				sv_q <= 1'b0;
			end
		end else if (vld_s[69]) begin
			if (ov_q && out_stall) begin
				sv_q <= 1'b1;
			end else begin
				ov_q <= 1'b1;
			end
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (!out_stall) begin
				out_q <= skid_q;
			end
		end else if (vld_s[69]) begin
			if (ov_q && out_stall) begin
				skid_q <= fin;
			end else begin
				out_q <= fin;
			end
		end
	end

	assign out_valid     = ov_q;
	assign pixel_u       = out_q.pixel_u;
	assign pixel_v       = out_q.pixel_v;
	assign jac_u_x       = out_q.jac_u_x;
	assign jac_u_y       = out_q.jac_u_y;
	assign jac_u_z       = out_q.jac_u_z;
	assign jac_v_x       = out_q.jac_v_x;
	assign jac_v_y       = out_q.jac_v_y;
	assign jac_v_z       = out_q.jac_v_z;
	assign depth_invalid = out_q.depth_invalid;

`include "distorted_pinhole_projection_assert.svh"

	`DPP_ASSERT_NOW(a_skid_has_out, sv_q, ov_q, "skid word held without an output word")
	`DPP_ASSERT_NEXT(a_skid_fill, !sv_q && vld_s[69] && ov_q && out_stall, sv_q,
		"word leaving the pipeline was not caught by the skid entry")
	`DPP_ASSERT_NOW(a_bad_depth_zero, ov_q && out_q.depth_invalid,
		out_q.pixel_u == 32'sd0 && out_q.jac_u_z == 32'sd0 && out_q.jac_v_y == 32'sd0,
		"invalid depth word carries nonzero fields")

endmodule

// ----- test/distorted_pinhole_projection_checker.sv -----
`timescale 1ns / 1ps

module distorted_pinhole_projection_checker import dpp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] pixel_u,
	input  logic signed [31:0] pixel_v,
	input  logic signed [31:0] jac_u_x,
	input  logic signed [31:0] jac_u_y,
	input  logic signed [31:0] jac_u_z,
	input  logic signed [31:0] jac_v_x,
	input  logic signed [31:0] jac_v_y,
	input  logic signed [31:0] jac_v_z,
	input  logic               depth_invalid,
	output int                 errors,
	output int                 pending,
	output int                 checked,
	output int                 invalid_seen
);

	localparam longint LMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint LMIN = 64'sh8000_0000_0000_0000;
	localparam longint LONE = 64'sh0000_0001_0000_0000;

	logic [31:0] fx_reg, fy_reg, k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
	logic [63:0] pp_reg;
	res_t pixel_queue[$];

	function automatic longint clamp_mag(bit neg, logic [127:0] m);
		if (m[127:63] != 0) begin
			return neg ? LMIN : LMAX;
		end
		return neg ? -longint'(m[62:0]) : longint'(m[62:0]);
	endfunction

	function automatic logic [63:0] magnitude(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint mul_round(longint a, longint b, int sh);
		logic [127:0] p;
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		if (sh > 0) begin
			p = (p + (128'd1 << (sh - 1))) >> sh;
		end
		return clamp_mag((a < 0) != (b < 0), p);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return mul_round(a, b, 32);
	endfunction

	function automatic longint qadd(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(LMAX)) begin
			return LMAX;
		end
		if (s < 65'(LMIN)) begin
			return LMIN;
		end
		return longint'(s);
	endfunction

	function automatic longint qneg(longint a);
		return a == LMIN ? LMAX : -a;
	endfunction

	function automatic longint qdiv(longint n, longint d);
		logic [63:0] m, q;
		m = magnitude(n) << 32;
		q = (m + 64'(d) / 2) / 64'(d);
		return clamp_mag(n < 0, {64'd0, q});
	endfunction

	function automatic logic signed [31:0] to_pixel(longint a);
		longint r;
		r = mul_round(a, 1, 16);
		if (r > 64'sh7FFF_FFFF) begin
			r = 64'sh7FFF_FFFF;
		end
		if (r < -64'sh8000_0000) begin
			r = -64'sh8000_0000;
		end
		return r[31:0];
	endfunction

	function automatic res_t project_point(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		res_t r;
		longint fx, fy, cx, cy, k1, k2, k3, p1, p2;
		longint u, v, w, u2, v2, uv, r2, r4, r6, dr, tx, ty, xd, yd;
		longint g, a, b, d, sx, sy;
		r = '0;
		if (pz <= 0) begin
			r.depth_invalid = 1'b1;
			return r;
		end
		fx = longint'(fx_reg) << 16;
		fy = longint'(fy_reg) << 16;
		cx = longint'(pp_reg[31:0]) << 16;
		cy = longint'(pp_reg[63:32]) << 16;
		k1 = longint'($signed(k1_reg)) * 16;
		k2 = longint'($signed(k2_reg)) * 16;
		k3 = longint'($signed(k3_reg)) * 16;
		p1 = longint'($signed(p1_reg)) * 16;
		p2 = longint'($signed(p2_reg)) * 16;
		u = qdiv(px, pz);
		v = qdiv(py, pz);
		w = qdiv(65536, pz);
		u2 = qmul(u, u);
		v2 = qmul(v, v);
		uv = qmul(u, v);
		r2 = qadd(u2, v2);
		r4 = qmul(r2, r2);
		r6 = qmul(r4, r2);
		dr = qadd(qadd(qadd(LONE, qmul(k1, r2)), qmul(k2, r4)), qmul(k3, r6));
		tx = qadd(mul_round(qmul(p1, uv), 2, 0), qmul(p2, qadd(r2, mul_round(u2, 2, 0))));
		ty = qadd(qmul(p1, qadd(r2, mul_round(v2, 2, 0))), mul_round(qmul(p2, uv), 2, 0));
		xd = qadd(qmul(dr, u), tx);
		yd = qadd(qmul(dr, v), ty);
		g = qadd(qadd(k1, mul_round(qmul(k2, r2), 2, 0)), mul_round(qmul(k3, r4), 3, 0));
		a = qadd(qadd(qadd(dr, mul_round(qmul(u2, g), 2, 0)), mul_round(qmul(p1, v), 2, 0)),
			mul_round(qmul(p2, u), 6, 0));
		b = qadd(qadd(mul_round(qmul(uv, g), 2, 0), mul_round(qmul(p1, u), 2, 0)),
			mul_round(qmul(p2, v), 2, 0));
		d = qadd(qadd(qadd(dr, mul_round(qmul(v2, g), 2, 0)), mul_round(qmul(p1, v), 6, 0)),
			mul_round(qmul(p2, u), 2, 0));
		sx = qadd(qmul(a, u), qmul(b, v));
		sy = qadd(qmul(b, u), qmul(d, v));
		r.pixel_u = to_pixel(qadd(cx, qmul(fx, xd)));
		r.pixel_v = to_pixel(qadd(cy, qmul(fy, yd)));
		r.jac_u_x = to_pixel(qmul(fx, qmul(a, w)));
		r.jac_u_y = to_pixel(qmul(fx, qmul(b, w)));
		r.jac_u_z = to_pixel(qneg(qmul(fx, qmul(sx, w))));
		r.jac_v_x = to_pixel(qmul(fy, qmul(b, w)));
		r.jac_v_y = to_pixel(qmul(fy, qmul(d, w)));
		r.jac_v_z = to_pixel(qneg(qmul(fy, qmul(sy, w))));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_reg <= 32'd65536;
			fy_reg <= 32'd65536;
			pp_reg <= '0;
			k1_reg <= '0;
			k2_reg <= '0;
			k3_reg <= '0;
			p1_reg <= '0;
			p2_reg <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:   fx_reg <= cfg_data[31:0];
				REG_FOCAL_Y:   fy_reg <= cfg_data[31:0];
				REG_PRINCIPAL: pp_reg <= cfg_data;
				REG_RADIAL_K1: k1_reg <= cfg_data[31:0];
				REG_RADIAL_K2: k2_reg <= cfg_data[31:0];
				REG_RADIAL_K3: k3_reg <= cfg_data[31:0];
				REG_TANG_P1:   p1_reg <= cfg_data[31:0];
				REG_TANG_P2:   p2_reg <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	initial begin
		errors = 0;
		checked = 0;
		invalid_seen = 0;
	end

	assign pending = pixel_queue.size();

	always @(posedge clk) begin
		res_t want;
		logic [31:0] exp_f[9];
		logic [31:0] act_f[9];
		string names[9];
		names = '{"pixel_u", "pixel_v", "jac_u_x", "jac_u_y", "jac_u_z", "jac_v_x",
			"jac_v_y", "jac_v_z", "depth_invalid"};
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pixel_queue.push_back(project_point(point_x, point_y, point_z));
			end
			if (out_valid && !out_stall) begin
				checked++;
				if (depth_invalid) begin
					invalid_seen++;
				end
				if (pixel_queue.size() == 0) begin
					errors++;
					$display("%0t: result word with no point outstanding", $time);
				end else begin
					want = pixel_queue.pop_front();
					exp_f = '{want.pixel_u, want.pixel_v, want.jac_u_x, want.jac_u_y,
						want.jac_u_z, want.jac_v_x, want.jac_v_y, want.jac_v_z,
						32'(want.depth_invalid)};
					act_f = '{pixel_u, pixel_v, jac_u_x, jac_u_y, jac_u_z, jac_v_x,
						jac_v_y, jac_v_z, 32'(depth_invalid)};
					for (int i = 0; i < 9; i++) begin
						if (exp_f[i] !== act_f[i]) begin
							errors++;
							$display("%0t: %s expected %h actual %h", $time, names[i],
								exp_f[i], act_f[i]);
						end
					end
				end
			end
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import dpp_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [3:0]         cfg_index = '0;
	logic [63:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] pixel_u, pixel_v, jac_u_x, jac_u_y, jac_u_z;
	logic signed [31:0] jac_v_x, jac_v_y, jac_v_z;
	logic               depth_invalid;
	int                 errors, pending, checked, invalid_seen;
	int                 idle_cycles = 0;
	int                 sent = 0;
	bit                 calm = 1'b0;

	always #4 clk = ~clk;

	distorted_pinhole_projection i_dut (.*);

	distorted_pinhole_projection_checker i_checker (.*);

	always @(posedge clk) begin
		int burst;
		if (calm) begin
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 9);
			out_stall <= 1'b1;
			repeat (burst) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= 5000) begin
			$display("distorted_pinhole_projection regression: fail");
			$finish;
		end
	end

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_camera(logic [31:0] fx, logic [31:0] fy, logic [63:0] pp,
			logic [31:0] k1, logic [31:0] k2, logic [31:0] k3, logic [31:0] p1,
			logic [31:0] p2);
		drain();
		write_reg(REG_FOCAL_X, {32'd0, fx});
		write_reg(REG_FOCAL_Y, {32'd0, fy});
		write_reg(REG_PRINCIPAL, pp);
		write_reg(REG_RADIAL_K1, {32'd0, k1});
		write_reg(REG_RADIAL_K2, {32'd0, k2});
		write_reg(REG_RADIAL_K3, {32'd0, k3});
		write_reg(REG_TANG_P1, {32'd0, p1});
		write_reg(REG_TANG_P2, {32'd0, p2});
	endtask

	function automatic logic [31:0] lens_coef();
		case ($urandom_range(0, 3))
			0: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
		endcase
	endfunction

	task automatic random_points(int count);
		logic signed [31:0] z, x, y;
		repeat (count) begin
			case ($urandom_range(0, 9))
				0: send_point($urandom, $urandom, $urandom);
				1: send_point($urandom, $urandom, -$signed($urandom_range(0, 32'h7FFF_FFFF)));
				default: begin
					z = $urandom_range(1, 32'h00FF_FFFF);
					x = $signed($urandom_range(0, 2 * z)) - z;
					y = $signed($urandom_range(0, 2 * z)) - z;
					send_point(x, y, z);
				end
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(0, 0, 32'h0001_0000);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
		send_point(0, 0, 0);
		send_point(32'h1234_5678, 32'h0765_4321, 0);
		send_point(0, 0, 32'hFFFF_FFFF);
		send_point(0, 0, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
		send_point(32'hFFFF_0000, 32'h0001_8000, 32'h0000_8000);

		load_camera(32'h0280_0000, 32'h01E0_0000, {32'h00F0_0000, 32'h0140_0000},
			32'hFC00_0000, 32'h0100_0000, 32'hFFE0_0000, 32'h0001_0000, 32'hFFFF_0000);
		send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
		send_point(32'h0003_0000, 32'h0004_0000, 32'h0001_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		drain();
		write_reg(4'd9, 64'hFFFF_FFFF_FFFF_FFFF);
		random_points(240);

		load_camera(32'hFFFF_FFFF, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
		random_points(200);

		load_camera(0, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000);
		random_points(200);

		repeat (2) begin
			load_camera($urandom_range(32'h0001_0000, 32'h0800_0000),
				$urandom_range(32'h0001_0000, 32'h0800_0000), {$urandom, $urandom},
				lens_coef(), lens_coef(), lens_coef(), lens_coef(), lens_coef());
			random_points(200);
		end

		calm = 1'b1;
		random_points(180);

		drain();
		repeat (100) @(posedge clk);
		$display("Sent %0d points through six camera setups; %0d results checked,",
			sent, checked);
		$display("%0d of them with bad depth.", invalid_seen);
		if (errors == 0 && pending == 0) begin
			$display("distorted_pinhole_projection regression: pass");
		end else begin
			$display("distorted_pinhole_projection regression: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/dpp_pkg.sv
sv/dpp_div.sv
sv/dpp_mul.sv
sv/distorted_pinhole_projection.sv
test/distorted_pinhole_projection_checker.sv
test/testbench.sv
